// ===== hw/rtl/mbgf_pkg.sv =====
// Package for the multi-bus gain fader: widths, reset values, command codes
// and the music-bus test. Depends on nothing; used by multi_bus_gain_fader_core.
`timescale 1ns / 1ps

package mbgf_pkg;

    // Bus addressing: every bus_select code names a bus.
    localparam int BUS_W     = 2;
    localparam int NUM_BUSES = 1 << BUS_W;
    localparam int MUSIC_BUS = 1;

    // Field widths and fixed-point layout.
    localparam int Q15_W      = 17;
    localparam int TICK_W     = 16;
    localparam int EXTRA_BITS = 16;
    localparam int GAIN_W     = Q15_W + EXTRA_BITS;
    localparam int EFF_W      = 19;
    localparam int EFF1_W     = 18;
    localparam int Q31_SHIFT  = 31;

    // Shift-add multiplier and restoring divider sizes.
    localparam int MUL_B_W   = 19;
    localparam int PROD_W    = GAIN_W + MUL_B_W;
    localparam int STEP_W    = GAIN_W + TICK_W;
    localparam int CNT_W     = 6;
    localparam int DIV_STEPS = GAIN_W;
    localparam int MUL_STEPS = MUL_B_W;

    typedef logic [1:0]        func_t;
    typedef logic [Q15_W-1:0]  q15_t;
    typedef logic [GAIN_W-1:0] gain_t;

    // Command codes.
    localparam func_t FUNC_FADE  = 2'd0;
    localparam func_t FUNC_TICK  = 2'd1;
    localparam func_t FUNC_QUERY = 2'd2;

    localparam q15_t  MAX_Q15    = q15_t'(65536);
    localparam q15_t  UNITY_Q15  = q15_t'(32768);
    localparam gain_t UNITY_GAIN = {UNITY_Q15, {EXTRA_BITS{1'b0}}};

    // The master and the music bus drive the refresh flag.
    function automatic logic music_related(input logic [BUS_W-1:0] b);
        return (b == '0) || (int'(b) == MUSIC_BUS);
    endfunction

endpackage

// ===== hw/rtl/multi_bus_gain_fader_core.sv =====
// Multi-bus gain fader: per-bus gain, target and ramp rate with a shared
// bit-serial multiplier and divider. Depends on mbgf_pkg.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_stall) carries one command beat: func,
//   bus_select, gain_value, ticks. A beat is taken when in_valid is high and
//   in_stall is low. Commands are worked one at a time; in_stall is high
//   while a command is in progress.
// - Output channel (out_valid / out_stall) returns exactly one result beat
//   per command: bus_gain, scaled_gain, music_moved. A result waits in
//   the output register while out_stall is high, and the next command can
//   already be accepted and worked meanwhile; it finishes once the register
//   is free.
// - Arithmetic done per command:
//     immediate set, unused code, zero-tick tick: no divide or multiply
//     fade with a duration: 33-step restoring divider
//     query: one multiply on the master, two on another bus (19-step multiplier
//       per factor)
//     tick: one 19-step multiply per ramping bus
//   A new command is accepted the cycle after the previous one finishes.
// - Reset puts every bus at unity gain with a unity target and no ramp,
//   and empties the output register.

module multi_bus_gain_fader_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    func,
    input  logic [mbgf_pkg::BUS_W-1:0]    bus_select,
    input  logic [mbgf_pkg::Q15_W-1:0]    gain_value,
    input  logic [mbgf_pkg::TICK_W-1:0]   ticks,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mbgf_pkg::Q15_W-1:0]    bus_gain,
    output logic [mbgf_pkg::EFF_W-1:0]    scaled_gain,
    output logic                          music_moved
);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd2;
    localparam logic [3:0] S_FADE_WR  = 4'd3;
    localparam logic [3:0] S_TICK_CHK = 4'd4;
    localparam logic [3:0] S_TICK_UPD = 4'd5;
    localparam logic [3:0] S_MUL      = 4'd6;
    localparam logic [3:0] S_Q_MID    = 4'd7;
    localparam logic [3:0] S_Q_LOAD2  = 4'd8;
    localparam logic [3:0] S_Q_END    = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    localparam logic [mbgf_pkg::BUS_W-1:0] LAST_BUS =
        mbgf_pkg::BUS_W'(mbgf_pkg::NUM_BUSES - 1);

    // Per-bus state, read and written at idx_reg only.
    mbgf_pkg::gain_t gain_mem_reg   [mbgf_pkg::NUM_BUSES];
    mbgf_pkg::q15_t  target_mem_reg [mbgf_pkg::NUM_BUSES];
    mbgf_pkg::gain_t rate_mem_reg   [mbgf_pkg::NUM_BUSES];

    logic                          gain_we;
    mbgf_pkg::gain_t               gain_wdata;
    logic                          target_we;
    mbgf_pkg::q15_t                target_wdata;
    logic                          rate_we;
    mbgf_pkg::gain_t               rate_wdata;

    // Control and working registers.
    logic [3:0]                    state_reg, state_next;
    logic [3:0]                    ret_reg, ret_next;
    logic [mbgf_pkg::BUS_W-1:0]    idx_reg, idx_next;
    logic [mbgf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    mbgf_pkg::func_t               func_reg, func_next;
    logic [mbgf_pkg::BUS_W-1:0]    bus_reg, bus_next;
    mbgf_pkg::q15_t                gv_reg, gv_next;
    logic [mbgf_pkg::TICK_W-1:0]   ticks_reg, ticks_next;
    logic                          diff_nz_reg, diff_nz_next;
    mbgf_pkg::gain_t               quo_reg, quo_next;
    logic [mbgf_pkg::TICK_W-1:0]   rem_reg, rem_next;
    mbgf_pkg::gain_t               mul_a_reg, mul_a_next;
    logic [mbgf_pkg::MUL_B_W-1:0]  mul_b_reg, mul_b_next;
    logic [mbgf_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [mbgf_pkg::EFF_W-1:0]    eff_reg, eff_next;
    logic                          moved_reg, moved_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    mbgf_pkg::q15_t                out_gain_reg, out_gain_next;
    logic [mbgf_pkg::EFF_W-1:0]    out_eff_reg, out_eff_next;
    logic                          out_moved_reg, out_moved_next;

    // Datapath terms.
    logic                          accept;
    mbgf_pkg::q15_t                gv_clamped;
    mbgf_pkg::gain_t               g_cur;
    mbgf_pkg::gain_t               t_cur;
    mbgf_pkg::gain_t               t_fade;
    mbgf_pkg::gain_t               fade_diff;
    logic                          tick_up;
    mbgf_pkg::gain_t               tick_dist;
    logic [mbgf_pkg::STEP_W-1:0]   tick_step;
    logic                          tick_reach;
    mbgf_pkg::gain_t               tick_gain;
    logic [mbgf_pkg::GAIN_W:0]     mul_sum;
    logic [mbgf_pkg::TICK_W:0]     div_shift;
    logic [mbgf_pkg::TICK_W:0]     div_trial;
    logic                          div_ge;
    logic [mbgf_pkg::EFF1_W-1:0]   eff1;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign bus_gain  = out_gain_reg;
    assign scaled_gain    = out_eff_reg;
    assign music_moved    = out_moved_reg;

    // Requested gains saturate at 2.0.
    assign gv_clamped = (gain_value > mbgf_pkg::MAX_Q15) ? mbgf_pkg::MAX_Q15 : gain_value;

    // Current bus entry and its target in Q2.31.
    assign g_cur  = gain_mem_reg[idx_reg];
    assign t_cur  = {target_mem_reg[idx_reg], {mbgf_pkg::EXTRA_BITS{1'b0}}};
    assign t_fade = {gv_reg, {mbgf_pkg::EXTRA_BITS{1'b0}}};
    assign fade_diff = (g_cur > t_fade) ? (g_cur - t_fade) : (t_fade - g_cur);

    // Tick update: move toward the target, stop exactly on it.
    assign tick_step  = prod_reg[mbgf_pkg::STEP_W-1:0];
    assign tick_up    = (g_cur < t_cur);
    assign tick_dist  = tick_up ? (t_cur - g_cur) : (g_cur - t_cur);
    assign tick_reach = ({{(mbgf_pkg::STEP_W - mbgf_pkg::GAIN_W){1'b0}}, tick_dist}
                         <= tick_step);
    assign tick_gain  = tick_reach ? t_cur :
                        (tick_up ? (g_cur + tick_step[mbgf_pkg::GAIN_W-1:0])
                                 : (g_cur - tick_step[mbgf_pkg::GAIN_W-1:0]));

    // One shift-add step of the multiplier: one multiplier bit per cycle.
    assign mul_sum = {1'b0, prod_reg[mbgf_pkg::PROD_W-1:mbgf_pkg::MUL_B_W]}
                   + (mul_b_reg[0] ? {1'b0, mul_a_reg} : '0);

    // One step of the restoring divider: one quotient bit per cycle.
    assign div_shift = {rem_reg, quo_reg[mbgf_pkg::GAIN_W-1]};
    assign div_trial = div_shift - {1'b0, ticks_reg};
    assign div_ge    = (div_shift >= {1'b0, ticks_reg});

    // First query product, truncated to Q3.15.
    assign eff1 = prod_reg[mbgf_pkg::Q31_SHIFT +: mbgf_pkg::EFF1_W];

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        bus_next       = bus_reg;
        gv_next        = gv_reg;
        ticks_next     = ticks_reg;
        diff_nz_next   = diff_nz_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        prod_next      = prod_reg;
        eff_next       = eff_reg;
        moved_next     = moved_reg;
        gain_we        = 1'b0;
        gain_wdata     = t_fade;
        target_we      = 1'b0;
        target_wdata   = gv_reg;
        rate_we        = 1'b0;
        rate_wdata     = '0;
        out_valid_next = out_valid_reg;
        out_gain_next  = out_gain_reg;
        out_eff_next   = out_eff_reg;
        out_moved_next = out_moved_reg;

        // The receiver took the waiting result.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    bus_next   = bus_select;
                    gv_next    = gv_clamped;
                    ticks_next = ticks;
                    eff_next   = '0;
                    moved_next = 1'b0;
                    idx_next   = (func == mbgf_pkg::FUNC_TICK || func == mbgf_pkg::FUNC_QUERY)
                                 ? '0 : bus_select;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (func_reg)
                    mbgf_pkg::FUNC_FADE:
                    begin
                        if (ticks_reg == '0)
                        begin
                            // Immediate set.
                            gain_we    = 1'b1;
                            gain_wdata = t_fade;
                            target_we  = 1'b1;
                            rate_we    = 1'b1;
                            rate_wdata = '0;
                            moved_next = mbgf_pkg::music_related(idx_reg);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            quo_next     = fade_diff;
                            rem_next     = '0;
                            diff_nz_next = (fade_diff != '0);
                            cnt_next     = '0;
                            state_next   = S_DIV;
                        end
                    end
                    mbgf_pkg::FUNC_TICK:
                    begin
                        if (ticks_reg == '0)
                        begin
                            idx_next   = bus_reg;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_TICK_CHK;
                        end
                    end
                    mbgf_pkg::FUNC_QUERY:
                    begin
                        // Requested gain times the master gain.
                        mul_a_next = g_cur;
                        mul_b_next = {{(mbgf_pkg::MUL_B_W - mbgf_pkg::Q15_W){1'b0}}, gv_reg};
                        prod_next  = '0;
                        cnt_next   = '0;
                        ret_next   = S_Q_MID;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DIV:
            begin
                rem_next = div_ge ? div_trial[mbgf_pkg::TICK_W-1:0]
                                  : div_shift[mbgf_pkg::TICK_W-1:0];
                quo_next = {quo_reg[mbgf_pkg::GAIN_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == mbgf_pkg::CNT_W'(mbgf_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_FADE_WR;
                end
            end

            S_FADE_WR:
            begin
                // A nonzero difference always gets at least the smallest rate.
                target_we  = 1'b1;
                rate_we    = 1'b1;
                rate_wdata = (quo_reg == '0 && diff_nz_reg) ? mbgf_pkg::gain_t'(1) : quo_reg;
                state_next = S_DONE;
            end

            S_TICK_CHK:
            begin
                if (rate_mem_reg[idx_reg] == '0 || g_cur == t_cur)
                begin
                    if (idx_reg == LAST_BUS)
                    begin
                        idx_next   = bus_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    // Step length is rate times elapsed ticks.
                    mul_a_next = rate_mem_reg[idx_reg];
                    mul_b_next = {{(mbgf_pkg::MUL_B_W - mbgf_pkg::TICK_W){1'b0}}, ticks_reg};
                    prod_next  = '0;
                    cnt_next   = '0;
                    ret_next   = S_TICK_UPD;
                    state_next = S_MUL;
                end
            end

            S_TICK_UPD:
            begin
                gain_we    = 1'b1;
                gain_wdata = tick_gain;
                if (tick_reach)
                begin
                    rate_we    = 1'b1;
                    rate_wdata = '0;
                end
                if (mbgf_pkg::music_related(idx_reg))
                begin
                    moved_next = 1'b1;
                end
                if (idx_reg == LAST_BUS)
                begin
                    idx_next   = bus_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TICK_CHK;
                end
            end

            S_MUL:
            begin
                prod_next  = {mul_sum, prod_reg[mbgf_pkg::MUL_B_W-1:1]};
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == mbgf_pkg::CNT_W'(mbgf_pkg::MUL_STEPS - 1))
                begin
                    state_next = ret_reg;
                end
            end

            S_Q_MID:
            begin
                if (bus_reg == '0)
                begin
                    eff_next   = {1'b0, eff1};
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = bus_reg;
                    mul_b_next = {{(mbgf_pkg::MUL_B_W - mbgf_pkg::EFF1_W){1'b0}}, eff1};
                    state_next = S_Q_LOAD2;
                end
            end

            S_Q_LOAD2:
            begin
                // Second factor: the selected bus gain.
                mul_a_next = g_cur;
                prod_next  = '0;
                cnt_next   = '0;
                ret_next   = S_Q_END;
                state_next = S_MUL;
            end

            S_Q_END:
            begin
                eff_next   = prod_reg[mbgf_pkg::Q31_SHIFT +: mbgf_pkg::EFF_W];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // idx_reg points at the selected bus here.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_gain_next  = g_cur[mbgf_pkg::GAIN_W-1 -: mbgf_pkg::Q15_W];
                    out_eff_next   = eff_reg;
                    out_moved_next = moved_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Per-bus state with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mbgf_pkg::NUM_BUSES; i++)
            begin
                gain_mem_reg[i]   <= mbgf_pkg::UNITY_GAIN;
                target_mem_reg[i] <= mbgf_pkg::UNITY_Q15;
                rate_mem_reg[i]   <= '0;
            end
        end
        else
        begin
            if (gain_we)
            begin
                gain_mem_reg[idx_reg] <= gain_wdata;
            end
            if (target_we)
            begin
                target_mem_reg[idx_reg] <= target_wdata;
            end
            if (rate_we)
            begin
                rate_mem_reg[idx_reg] <= rate_wdata;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        bus_reg       <= bus_next;
        gv_reg        <= gv_next;
        ticks_reg     <= ticks_next;
        diff_nz_reg   <= diff_nz_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        prod_reg      <= prod_next;
        eff_reg       <= eff_next;
        moved_reg     <= moved_next;
        out_gain_reg  <= out_gain_next;
        out_eff_reg   <= out_eff_next;
        out_moved_reg <= out_moved_next;
    end

endmodule
